// ===== rtl/core/b64ld_pkg.sv =====
// ----------------------------------------------------------------------------
// b64ld_pkg
// Shared types, constants and decode helpers for the base64 line decoder.
// ----------------------------------------------------------------------------
package b64ld_pkg;

	// Line length limits and the width and reset value of the configuration register
	localparam int LINE_CHARS_DEF = 76;
	localparam int LINE_CHARS_HI  = 76;
	localparam int LEN_W          = 7;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(LINE_CHARS_DEF);

	// Byte count of one line, sized for the longest line allowed
	localparam int CNT_W  = $clog2(LINE_CHARS_HI / 4 * 3 + 1);
	localparam int HOLD_W = 18;
	localparam int WORD_W = 24;

	// Run descriptor queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Character codes
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_PAD  = 8'h3D;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [5:0] SEXTET_OTHER = 6'd63;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} back_state_t;

	// One entry of the run queue: a decoded line in a bank, or a halt marker
	typedef struct packed {
		logic             is_halt;
		logic             bank;
		logic [CNT_W-1:0] count;
	} run_desc_t;

	// Back tells front that a bank has been drained
	typedef struct packed {
		logic en;
		logic bank;
	} bank_free_t;

	// Per-line decode state
	typedef struct packed {
		logic [HOLD_W-1:0] hold;
		logic [1:0]        place;
		logic [LEN_W-1:0]  chars;
		logic              pad;
	} line_st_t;

	// Outcome of adding one character to the line
	typedef struct packed {
		line_st_t          st;
		logic              ok;
		logic              wr;
		logic [WORD_W-1:0] word;
		logic [1:0]        nbytes;
	} take_res_t;

	function automatic logic [5:0] sextet_of(logic [7:0] c);
		logic [5:0] s;
		s = SEXTET_OTHER;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			s = 6'(c - 8'h61) + 6'd26;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			s = 6'(c - 8'h30) + 6'd52;
		end else if (c == CHAR_PLUS) begin
			s = 6'd62;
		end
		return s;
	endfunction

	// Add one character to the line; ok drops when the line would overflow.
	// A completed group (or a padded one) yields one 24-bit word whose
	// leading nbytes bytes are the decoded data.
	function automatic take_res_t take_char(line_st_t st, logic [7:0] c,
			logic [LEN_W-1:0] lim);
		take_res_t  r;
		logic [5:0] s;
		r        = '0;
		r.st     = st;
		r.ok     = 1'b1;
		s        = sextet_of(c);
		if (st.chars >= lim) begin
			r.ok = 1'b0;
		end else begin
			r.st.chars = st.chars + LEN_W'(1);
			if (!st.pad) begin
				unique case (st.place)
					2'd0, 2'd1: begin
						r.st.hold  = {st.hold[11:0], s};
						r.st.place = st.place + 2'd1;
					end
					2'd2: begin
						if (c == CHAR_PAD) begin
							r.wr       = 1'b1;
							r.word     = {st.hold[11:0], 12'd0};
							r.nbytes   = 2'd1;
							r.st.pad   = 1'b1;
							r.st.hold  = '0;
							r.st.place = 2'd0;
						end else begin
							r.st.hold  = {st.hold[11:0], s};
							r.st.place = 2'd3;
						end
					end
					2'd3: begin
						r.wr = 1'b1;
						if (c == CHAR_PAD) begin
							r.word   = {st.hold, 6'd0};
							r.nbytes = 2'd2;
							r.st.pad = 1'b1;
						end else begin
							r.word   = {st.hold, s};
							r.nbytes = 2'd3;
						end
						r.st.hold  = '0;
						r.st.place = 2'd0;
					end
				endcase
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/b64ld_ram.sv =====
// ----------------------------------------------------------------------------
// b64ld_ram
// Two-bank line store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module b64ld_ram #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 24
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write a decoded group
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read a group for draining
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/b64ld_queue.sv =====
// ----------------------------------------------------------------------------
// b64ld_queue
// Short queue of run descriptors from the decode front to the drain back.
// ----------------------------------------------------------------------------
module b64ld_queue
	import b64ld_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  run_desc_t wr_desc,
	output logic      q_full,
	input  logic      rd_en,
	output run_desc_t rd_desc,
	output logic      q_empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	run_desc_t         entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign q_full  = (count_q == CNT_QW'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_desc = entry_q[rd_ptr_q];

	// Store a descriptor
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_desc;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/b64ld_front.sv =====
// ----------------------------------------------------------------------------
// b64ld_front
// Takes one text character per word, tracks CR LF line framing and length,
// decodes groups into the current bank and queues finished lines and halt markers.
// ----------------------------------------------------------------------------
module b64ld_front
	import b64ld_pkg::*;
#(
	parameter int MAX_LINE_CHARS = LINE_CHARS_DEF,
	parameter int GRP_W          = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [LEN_W-1:0]   cfg_wr_data,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         text_char,
	input  logic               end_of_text,
	output logic               wr_en,
	output logic [GRP_W:0]     wr_addr,
	output logic [WORD_W-1:0]  wr_data,
	output logic               q_wr_en,
	output run_desc_t          q_wr_desc,
	input  logic               q_full,
	input  bank_free_t         bank_free
);

	localparam logic [LEN_W-1:0] MAX_CHARS = LEN_W'(MAX_LINE_CHARS);

	logic [LEN_W-1:0] line_len_q;
	line_st_t         line_q;
	logic [CNT_W-1:0] byte_cnt_q;
	logic [GRP_W-1:0] grp_q;
	logic             cr_pend_q;
	logic             halted_q;
	logic             bank_sel_q;
	logic [1:0]       bank_busy_q;

	logic [LEN_W-1:0] lim;
	logic             acc;
	logic             line_done;
	logic             en_a;
	logic             en_b;
	take_res_t        res_a;
	take_res_t        res_b;
	line_st_t         st_mid;
	line_st_t         st_end;
	logic             bad_a;
	logic             bad_b;
	logic             bad_len;
	logic             bad;
	logic             emit;
	logic             wr_a;
	logic             wr_b;
	logic [CNT_W-1:0] bytes_new;
	logic             push_run;
	logic             push_halt;
	logic [1:0]       bank_busy_n;

	// Line length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			line_len_q <= cfg_wr_data;
		end
	end

	// Clamp the length and hold input while the target bank still drains or the run queue is full
	assign lim  = (line_len_q > MAX_CHARS) ? MAX_CHARS : line_len_q;
	assign full = q_full || bank_busy_q[bank_sel_q];
	assign acc  = push && !full;

	// Classify the character: a held CR not followed by LF is taken first, then this one
	always_comb begin
		line_done = cr_pend_q && (text_char == CHAR_LF);
		en_a      = cr_pend_q && !line_done;
		res_a     = take_char(line_q, CHAR_CR, lim);
		st_mid    = en_a ? res_a.st : line_q;
		en_b      = !line_done && ((text_char != CHAR_CR) || end_of_text);
		res_b     = take_char(st_mid, text_char, lim);
		st_end    = en_b ? res_b.st : st_mid;

		bad_a   = en_a && !res_a.ok;
		bad_b   = !bad_a && en_b && !res_b.ok;
		bad_len = line_done && (line_q.chars != lim);
		bad     = bad_a || bad_b || bad_len;
		emit    = !bad && (line_done || end_of_text);

		wr_a      = en_a && res_a.wr;
		wr_b      = en_b && res_b.wr;
		bytes_new = byte_cnt_q
			+ (en_a ? CNT_W'(res_a.nbytes) : CNT_W'(0))
			+ (en_b ? CNT_W'(res_b.nbytes) : CNT_W'(0));

		push_run  = acc && !halted_q && emit && (bytes_new != '0);
		push_halt = acc && !halted_q && bad;
	end

	// Group write into the current bank
	assign wr_en   = acc && !halted_q && !bad && (wr_a || wr_b);
	assign wr_addr = {bank_sel_q, grp_q};
	assign wr_data = wr_a ? res_a.word : res_b.word;

	// Queue a finished line or a halt marker
	always_comb begin
		q_wr_en   = push_run || push_halt;
		q_wr_desc = '0;
		if (push_halt) begin
			q_wr_desc.is_halt = 1'b1;
		end else begin
			q_wr_desc.bank  = bank_sel_q;
			q_wr_desc.count = bytes_new;
		end
	end

	// Bank ownership: set on queueing, clear when drained
	always_comb begin
		bank_busy_n = bank_busy_q;
		if (bank_free.en) begin
			bank_busy_n[bank_free.bank] = 1'b0;
		end
		if (push_run) begin
			bank_busy_n[bank_sel_q] = 1'b1;
		end
	end

	// Advance line state per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q      <= '0;
			byte_cnt_q  <= '0;
			grp_q       <= '0;
			cr_pend_q   <= 1'b0;
			halted_q    <= 1'b0;
			bank_sel_q  <= 1'b0;
			bank_busy_q <= '0;
		end else begin
			bank_busy_q <= bank_busy_n;
			if (acc) begin
				if (halted_q) begin
					if (end_of_text) begin
						line_q     <= '0;
						byte_cnt_q <= '0;
						grp_q      <= '0;
						cr_pend_q  <= 1'b0;
						halted_q   <= 1'b0;
					end
				end else if (bad || emit) begin
					line_q     <= '0;
					byte_cnt_q <= '0;
					grp_q      <= '0;
					cr_pend_q  <= 1'b0;
					halted_q   <= bad && !end_of_text;
					if (push_run) begin
						bank_sel_q <= !bank_sel_q;
					end
				end else begin
					line_q     <= st_end;
					byte_cnt_q <= bytes_new;
					cr_pend_q  <= (text_char == CHAR_CR);
					if (wr_a || wr_b) begin
						grp_q <= grp_q + GRP_W'(1);
					end
				end
			end
		end
	end

endmodule

// ===== rtl/core/b64ld_back.sv =====
// ----------------------------------------------------------------------------
// b64ld_back
// Drains queued lines from the bank store one byte per word, passes halt
// markers on, and presents results through an output register.
// ----------------------------------------------------------------------------
module b64ld_back
	import b64ld_pkg::*;
#(
	parameter int GRP_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  run_desc_t         q_head,
	output logic              q_rd_en,
	output logic              rd_en,
	output logic [GRP_W:0]    rd_addr,
	input  logic [WORD_W-1:0] rd_data,
	output bank_free_t        bank_free,
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        out_byte,
	output logic              run_end,
	output logic              halted_flag
);

	back_state_t      state_q, state_n;
	logic             bank_q, bank_n;
	logic [GRP_W-1:0] grp_q, grp_n;
	logic [1:0]       sel_q, sel_n;
	logic [CNT_W-1:0] left_q, left_n;
	logic             ov_q;
	logic             can_load;
	logic             load;
	logic [7:0]       ld_byte;
	logic             ld_end;
	logic             ld_halt;
	logic [7:0]       word_byte;

	assign empty    = !ov_q;
	assign can_load = !ov_q || pop;

	// Pick the current byte of the fetched group
	always_comb begin
		unique case (sel_q)
			2'd0:    word_byte = rd_data[23:16];
			2'd1:    word_byte = rd_data[15:8];
			default: word_byte = rd_data[7:0];
		endcase
	end

	// Next state and drain control
	always_comb begin
		state_n   = state_q;
		bank_n    = bank_q;
		grp_n     = grp_q;
		sel_n     = sel_q;
		left_n    = left_q;
		q_rd_en   = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = {bank_q, grp_q};
		bank_free = '0;
		load      = 1'b0;
		ld_byte   = '0;
		ld_end    = 1'b0;
		ld_halt   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					if (q_head.is_halt) begin
						if (can_load) begin
							load    = 1'b1;
							ld_halt = 1'b1;
							q_rd_en = 1'b1;
						end
					end else begin
						rd_en   = 1'b1;
						rd_addr = {q_head.bank, GRP_W'(0)};
						bank_n  = q_head.bank;
						grp_n   = '0;
						sel_n   = 2'd0;
						left_n  = q_head.count;
						q_rd_en = 1'b1;
						state_n = BK_EMIT;
					end
				end
			end
			BK_EMIT: begin
				if (can_load) begin
					load    = 1'b1;
					ld_byte = word_byte;
					ld_end  = (left_q == CNT_W'(1));
					left_n  = left_q - CNT_W'(1);
					if (left_q == CNT_W'(1)) begin
						bank_free.en   = 1'b1;
						bank_free.bank = bank_q;
						state_n        = BK_IDLE;
					end else if (sel_q == 2'd2) begin
						sel_n   = 2'd0;
						grp_n   = grp_q + GRP_W'(1);
						rd_en   = 1'b1;
						rd_addr = {bank_q, grp_q + GRP_W'(1)};
					end else begin
						sel_n = sel_q + 2'd1;
					end
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			ov_q    <= 1'b0;
			bank_q  <= 1'b0;
			grp_q   <= '0;
			sel_q   <= '0;
			left_q  <= '0;
		end else begin
			state_q <= state_n;
			bank_q  <= bank_n;
			grp_q   <= grp_n;
			sel_q   <= sel_n;
			left_q  <= left_n;
			if (load) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte    <= ld_byte;
			run_end     <= ld_end;
			halted_flag <= ld_halt;
		end
	end

endmodule

// ===== rtl/core/base64_line_decoder.sv =====
// ----------------------------------------------------------------------------
// base64_line_decoder
// Base64 mail-body decoder with CR LF line framing and per-line byte runs.
// ----------------------------------------------------------------------------
// Text is taken one character per cycle while full is low. Each line decodes
// into one of two memory banks; when a line closes (CR LF of exactly
// line_length characters, or end_of_text) its bytes leave as a run at one
// byte per cycle while pop keeps up, as the next line decodes into the
// other bank. Input stalls (full) only when a line would start in a bank
// whose previous run is still draining, or the two-entry run queue is full.
// A bad line length yields one result with halted_flag set, after which text
// is dropped until end_of_text. The user must see that line_length is written
// only while no text is in flight; the block itself does not enforce it.
module base64_line_decoder
	import b64ld_pkg::*;
#(
	parameter int MAX_LINE_CHARS = LINE_CHARS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [LEN_W-1:0] cfg_wr_data,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       text_char,
	input  logic             end_of_text,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       out_byte,
	output logic             run_end,
	output logic             halted_flag
);

	// A line may end in a group padded at its third character
	localparam int MAX_GROUPS = (MAX_LINE_CHARS + 1) / 4;
	localparam int GRP_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

	logic              wr_en;
	logic [GRP_W:0]    wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              rd_en;
	logic [GRP_W:0]    rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              q_wr_en;
	run_desc_t         q_wr_desc;
	logic              q_full;
	logic              q_rd_en;
	run_desc_t         q_head;
	logic              q_empty;
	bank_free_t        bank_free;

	// Decode front
	b64ld_front #(
		.MAX_LINE_CHARS(MAX_LINE_CHARS),
		.GRP_W(GRP_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.push       (push),
		.full       (full),
		.text_char  (text_char),
		.end_of_text(end_of_text),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.q_wr_en    (q_wr_en),
		.q_wr_desc  (q_wr_desc),
		.q_full     (q_full),
		.bank_free  (bank_free)
	);

	// Line bank store
	b64ld_ram #(
		.ADDR_W(GRP_W + 1),
		.DATA_W(WORD_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Run queue
	b64ld_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr_en),
		.wr_desc(q_wr_desc),
		.q_full (q_full),
		.rd_en  (q_rd_en),
		.rd_desc(q_head),
		.q_empty(q_empty)
	);

	// Drain back
	b64ld_back #(
		.GRP_W(GRP_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_rd_en    (q_rd_en),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.bank_free  (bank_free),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.halted_flag(halted_flag)
	);

endmodule

// ===== tb/sv/tb_base64_line_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_line_decoder
// Drives base64 mail-body text into the line decoder one character per input
// word, predicts every decoded byte and halt marker, and checks each output
// word in order. Covers CR LF framing, padding, stray characters, bad line
// lengths and several line_length settings, with random gaps on both sides.
// ----------------------------------------------------------------------------

import b64ld_pkg::*;

// One expected output word
typedef struct packed {
	logic [7:0] data;
	logic       last;
	logic       halt;
} dec_byte_t;

// Predicts decoded bytes per line and checks output words against them
class decoded_byte_board;
	dec_byte_t        expected_bytes[$];
	logic [LEN_W-1:0] line_len;
	logic [7:0]       line_buf[57];
	int unsigned      n_bytes;
	logic [17:0]      hold;
	logic [1:0]       place;
	int unsigned      n_chars;
	bit               pad;
	bit               cr_wait;
	bit               stopped;
	int               errors;

	function new();
		line_len = LEN_RESET;
		errors   = 0;
		wipe_text();
	endfunction

	function void set_len(logic [LEN_W-1:0] v);
		line_len = v;
	endfunction

	function int pending();
		return expected_bytes.size();
	endfunction

	function int unsigned lim();
		return (line_len > LINE_CHARS_HI) ? LINE_CHARS_HI : int'(line_len);
	endfunction

	function logic [5:0] sextet(logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41);
		if (c >= 8'h61 && c <= 8'h7A) return 6'(c - 8'h47);
		if (c >= 8'h30 && c <= 8'h39) return 6'(c + 8'h04);
		if (c == CHAR_PLUS) return 6'd62;
		return 6'd63;
	endfunction

	function void wipe_line();
		n_bytes = 0;
		hold    = '0;
		place   = 2'd0;
		n_chars = 0;
		pad     = 1'b0;
	endfunction

	function void wipe_text();
		wipe_line();
		cr_wait = 1'b0;
		stopped = 1'b0;
	endfunction

	function void store(logic [7:0] b);
		if (n_bytes < 57) begin
			line_buf[n_bytes] = b;
			n_bytes++;
		end
	endfunction

	// Add one character to the line; return 0 when the line overflows
	function bit decode_char(logic [7:0] c);
		logic [5:0] s;
		if (n_chars >= lim()) return 1'b0;
		n_chars++;
		if (pad) return 1'b1;
		s = sextet(c);
		case (place)
			2'd0, 2'd1: begin
				hold  = {hold[11:0], s};
				place = place + 2'd1;
			end
			2'd2: begin
				if (c == CHAR_PAD) begin
					store({hold[11:6], hold[5:4]});
					pad   = 1'b1;
					hold  = '0;
					place = 2'd0;
				end else begin
					hold  = {hold[11:0], s};
					place = 2'd3;
				end
			end
			default: begin
				store({hold[17:12], hold[11:10]});
				store({hold[9:6], hold[5:2]});
				if (c == CHAR_PAD) pad = 1'b1;
				else store({hold[1:0], s});
				hold  = '0;
				place = 2'd0;
			end
		endcase
		return 1'b1;
	endfunction

	// Queue the bytes of the current line as one run, then clear the line
	function void emit_line_bytes();
		for (int unsigned i = 0; i < n_bytes; i++)
			expected_bytes.push_back('{line_buf[i], (i + 1 == n_bytes), 1'b0});
		wipe_line();
	endfunction

	// Note one accepted input word; return 1 unless it was dropped after a halt
	function bit take_text_char(logic [7:0] c, logic eot);
		bit bad;
		bit closed;
		int mark;
		bad    = 1'b0;
		closed = 1'b0;
		mark   = expected_bytes.size();
		if (stopped) begin
			if (eot) wipe_text();
			return 1'b0;
		end
		if (cr_wait && c == CHAR_LF) begin
			cr_wait = 1'b0;
			closed  = 1'b1;
		end else begin
			if (cr_wait) begin
				cr_wait = 1'b0;
				if (!decode_char(CHAR_CR)) bad = 1'b1;
			end
			if (!bad) begin
				if (c == CHAR_CR) cr_wait = 1'b1;
				else if (!decode_char(c)) bad = 1'b1;
			end
		end
		if (!bad && closed) begin
			if (n_chars != lim()) bad = 1'b1;
			else emit_line_bytes();
		end
		if (!bad && eot) begin
			if (cr_wait) begin
				cr_wait = 1'b0;
				if (!decode_char(CHAR_CR)) bad = 1'b1;
			end
			if (!bad) emit_line_bytes();
		end
		// drop this step's bytes and post a single halt marker
		if (bad) begin
			while (expected_bytes.size() > mark) void'(expected_bytes.pop_back());
			stopped = 1'b1;
			expected_bytes.push_back('{8'h00, 1'b0, 1'b1});
		end
		if (eot) wipe_text();
		return 1'b1;
	endfunction

	task report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task check_decoded(logic [7:0] d, logic last, logic halt);
		dec_byte_t w;
		if (expected_bytes.size() == 0) begin
			report($sformatf("unexpected word byte=%02h last=%b halt=%b", d, last, halt));
			return;
		end
		w = expected_bytes.pop_front();
		if (d !== w.data)
			report($sformatf("out_byte %02h, want %02h", d, w.data));
		if (last !== w.last)
			report($sformatf("run_end %b, want %b (byte %02h)", last, w.last, w.data));
		if (halt !== w.halt)
			report($sformatf("halted_flag %b, want %b", halt, w.halt));
	endtask
endclass

module tb_base64_line_decoder;

	typedef enum int {
		FL_CLEAN,
		FL_PAD_TAIL,
		FL_NOISE,
		FL_STRAY_PAD
	} char_flavor_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [LEN_W-1:0] cfg_wr_data = '0;
	logic             push = 1'b0;
	logic             full;
	logic [7:0]       text_char = 8'h00;
	logic             end_of_text = 1'b0;
	logic             empty;
	logic             pop = 1'b0;
	logic [7:0]       out_byte;
	logic             run_end;
	logic             halted_flag;

	decoded_byte_board board = new();

	string      b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	logic [7:0] text_buf[$];
	int         cur_lim = LINE_CHARS_DEF;
	int         live_items = 0;
	bit         send_gaps = 1'b0;
	bit         pop_gaps = 1'b0;

	base64_line_decoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.full        (full),
		.text_char   (text_char),
		.end_of_text (end_of_text),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.run_end     (run_end),
		.halted_flag (halted_flag)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	initial begin
		#2000000;
		$display("tb_base64_line_decoder: done, errors");
		$finish;
	end

	function automatic logic [7:0] b64_char();
		return 8'(b64_alpha.getc($urandom_range(0, 63)));
	endfunction

	function automatic char_flavor_t pick_flavor();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 12) return FL_CLEAN;
		if (roll < 15) return FL_PAD_TAIL;
		if (roll < 18) return FL_NOISE;
		return FL_STRAY_PAD;
	endfunction

	// Append n alphabet characters, then spoil some of them per flavor
	function automatic void append_chars(int n, char_flavor_t flavor);
		int base;
		base = text_buf.size();
		for (int k = 0; k < n; k++) text_buf.push_back(b64_char());
		if (n == 0) return;
		case (flavor)
			FL_PAD_TAIL: begin
				text_buf[base + n - 1] = CHAR_PAD;
				if (n >= 2 && $urandom_range(0, 1) == 1) text_buf[base + n - 2] = CHAR_PAD;
			end
			FL_NOISE: begin
				repeat ($urandom_range(1, 3))
					text_buf[base + $urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
			end
			FL_STRAY_PAD: begin
				repeat ($urandom_range(1, 2))
					text_buf[base + $urandom_range(0, n - 1)] = CHAR_PAD;
			end
			default: ;
		endcase
	endfunction

	function automatic void load_string(string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++) text_buf.push_back(8'(s.getc(i)));
	endfunction

	// Offer one input word and hold it until accepted
	task automatic send_char(input logic [7:0] c, input logic last);
		bit taken;
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push        <= 1'b1;
		text_char   <= c;
		end_of_text <= last;
		do begin
			@(negedge clk);
			taken = (full === 1'b0);
			@(posedge clk);
		end while (!taken);
		// count every accepted word, dropped or not
		void'(board.take_text_char(c, last));
		live_items++;
	endtask

	// Send the built text, marking its last byte as end of text
	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], i == text_buf.size() - 1);
	endtask

	// Write line_length once nothing is in flight
	task automatic set_line_len(input int v);
		push <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= LEN_W'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_len(LEN_W'(v));
		cur_lim = (v > LINE_CHARS_HI) ? LINE_CHARS_HI : v;
	endtask

	// Build a text of full CR LF lines and a final segment, mostly well formed
	task automatic send_random_text();
		int n_lines;
		int n;
		int roll;
		text_buf.delete();
		n_lines = (cur_lim > 24) ? $urandom_range(0, 1) : $urandom_range(0, 3);
		for (int k = 0; k < n_lines; k++) begin
			roll = $urandom_range(0, 19);
			n = cur_lim;
			if (roll == 0) n = cur_lim + 1;
			else if (roll == 1) n = $urandom_range(0, cur_lim - 1);
			append_chars(n, pick_flavor());
			text_buf.push_back(CHAR_CR);
			text_buf.push_back(CHAR_LF);
		end
		n = ($urandom_range(0, 19) == 0) ? cur_lim + 1 : $urandom_range(0, cur_lim);
		append_chars(n, pick_flavor());
		// a CR as the very last byte counts as a character
		if ($urandom_range(0, 9) == 0) text_buf.push_back(CHAR_CR);
		if (text_buf.size() == 0) text_buf.push_back(b64_char());
		send_text();
	endtask

	function automatic int pick_len();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 7) return 4 * $urandom_range(1, 6);
		if (roll == 7) return $urandom_range(4, LINE_CHARS_HI);
		if (roll == 8) return LINE_CHARS_HI;
		return $urandom_range(LINE_CHARS_HI + 1, 127);
	endfunction

	// Pop output words with random holds and check each one
	initial begin : drain
		logic [7:0] got_byte;
		logic       got_last;
		logic       got_halt;
		bit         taken;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (pop_gaps && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			pop <= 1'b1;
			@(negedge clk);
			taken    = (empty === 1'b0);
			got_byte = out_byte;
			got_last = run_end;
			got_halt = halted_flag;
			@(posedge clk);
			if (taken) board.check_decoded(got_byte, got_last, got_halt);
		end
	end

	initial begin : stimulus
		int fixed_lens[4];
		int phase;
		fixed_lens = '{LINE_CHARS_HI, 127, 6, 4};
		phase = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero bytes, all-ones with pad in fourth and third place
		set_line_len(4);
		send_gaps = 1'b1;
		pop_gaps  = 1'b1;
		load_string("AAAA\015\012//8=\015\012/w==");
		send_text();
		// lone LF and lone CR as characters, trailing group dropped
		load_string("\012\015+");
		send_text();
		// overlong line halts, then short CR LF line halts
		load_string("ABCDE");
		send_text();
		load_string("AB\015\012");
		send_text();

		// Random phases over several line lengths, extremes first
		while (live_items < 320) begin
			set_line_len((phase < 4) ? fixed_lens[phase] : pick_len());
			repeat ($urandom_range(2, 4)) begin
				if (live_items < 320) begin
					if (live_items >= 260) begin
						send_gaps = 1'b0;
						pop_gaps  = 1'b0;
					end else begin
						send_gaps = ($urandom_range(0, 3) != 0);
						pop_gaps  = ($urandom_range(0, 3) != 0);
					end
					send_random_text();
				end
			end
			phase++;
		end

		// Drain and let any stray word show up
		push <= 1'b0;
		send_gaps = 1'b0;
		pop_gaps  = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (board.errors == 0)
			$display("tb_base64_line_decoder: done, clean");
		else
			$display("tb_base64_line_decoder: done, errors");
		$finish;
	end

endmodule

// ===== base64_line_decoder.f =====
rtl/core/b64ld_pkg.sv
rtl/core/b64ld_ram.sv
rtl/core/b64ld_queue.sv
rtl/core/b64ld_front.sv
rtl/core/b64ld_back.sv
rtl/core/base64_line_decoder.sv
tb/sv/tb_base64_line_decoder.sv
